### design/signed_multiply_divide_unit_macros.svh
// Assertion helpers used by the verification checker.
`ifndef SIGNED_MULTIPLY_DIVIDE_UNIT_MACROS_SVH
`define SIGNED_MULTIPLY_DIVIDE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SMDU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smdu: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SMDU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smdu: next-cycle check failed");

`endif

### design/smdu_pkg.sv
`timescale 1ns / 1ps

package smdu_pkg;

    localparam logic FUNC_MUL = 1'b0;
    localparam logic FUNC_DIV = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture operands and signs
        logic step;     // one shift-add or restoring iteration
        logic finish;   // sign fix-up into the output register
    } smdu_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_zero; // divide with a zero divisor, iterations skipped
    } smdu_stat_t;

endpackage

### design/smdu_datapath.sv
`timescale 1ns / 1ps

module smdu_datapath #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  smdu_pkg::smdu_cmd_t           cmd,
    input  logic signed [DATA_WIDTH-1:0]  lhs,
    input  logic signed [DATA_WIDTH-1:0]  rhs,
    input  logic                          func,
    output smdu_pkg::smdu_stat_t          stat,
    output logic signed [DATA_WIDTH-1:0]  result
);
    import smdu_pkg::*;

    // a: multiplicand, or dividend shifting out / quotient shifting in
    // b: multiplier, or divisor
    // acc: partial product, or partial remainder
    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic                  func_reg, func_next;
    logic                  neg_reg, neg_next;
    logic [DATA_WIDTH-1:0] res_reg, res_next;

    logic [DATA_WIDTH-1:0] mag_l, mag_r, mag_res;
    logic [DATA_WIDTH:0]   rem_sh, diff;

    assign mag_l = lhs[DATA_WIDTH-1] ? (~lhs + 1'b1) : lhs;
    assign mag_r = rhs[DATA_WIDTH-1] ? (~rhs + 1'b1) : rhs;

    assign rem_sh = {acc_reg, a_reg[DATA_WIDTH-1]};
    assign diff   = rem_sh - {1'b0, b_reg};

    assign mag_res = (func_reg == FUNC_DIV) ? a_reg : acc_reg;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        func_next = func_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        if (cmd.load)
        begin
            a_next    = mag_l;
            b_next    = mag_r;
            acc_next  = '0;
            func_next = func;
            neg_next  = lhs[DATA_WIDTH-1] ^ rhs[DATA_WIDTH-1];
        end
        else if (cmd.step)
        begin
            if (func_reg == FUNC_DIV)
            begin
                // restoring step: keep the difference when it did not go negative
                if (!diff[DATA_WIDTH])
                begin
                    acc_next = diff[DATA_WIDTH-1:0];
                    a_next   = {a_reg[DATA_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    acc_next = rem_sh[DATA_WIDTH-1:0];
                    a_next   = {a_reg[DATA_WIDTH-2:0], 1'b0};
                end
            end
            else
            begin
                if (b_reg[0])
                    acc_next = acc_reg + a_reg;
                a_next = {a_reg[DATA_WIDTH-2:0], 1'b0};
                b_next = {1'b0, b_reg[DATA_WIDTH-1:1]};
            end
        end
        if (cmd.finish)
        begin
            if (stat.div_zero)
                res_next = '0;
            else if (neg_reg)
                res_next = ~mag_res + 1'b1;
            else
                res_next = mag_res;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        func_reg <= func_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
    end

    assign stat.div_zero = (func_reg == FUNC_DIV) && (b_reg == '0);
    assign result        = res_reg;

endmodule

### design/smdu_ctrl.sv
`timescale 1ns / 1ps

module smdu_ctrl #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output smdu_pkg::smdu_cmd_t   cmd,
    input  smdu_pkg::smdu_stat_t  stat
);
    import smdu_pkg::*;

    localparam int CW = $clog2(DATA_WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIX
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    count_next = CW'(DATA_WIDTH - 1);
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (stat.div_zero)
                    state_next = S_FIX;
                else
                begin
                    cmd.step   = 1'b1;
                    count_next = count_reg - 1'b1;
                    if (count_reg == '0)
                        state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### design/signed_multiply_divide_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Content
// s_axis    in         tdata: lhs, rhs (low first); tuser: func
// m_axis    out        tdata: result
//
// An item runs from acceptance to its result as a load, one shift-add or restoring iteration
// per operand bit, and a sign fix-up into the output register.
// A divide by zero skips the iterations.
// The next item is accepted while a finished result still waits in the output register.
// Reset is asynchronous and clears the controller only; no clearing pass is needed.

module signed_multiply_divide_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,  // lhs, rhs
    input  logic                                  s_tuser,  // func
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]       m_tdata   // result
);
    import smdu_pkg::*;

    localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

    smdu_cmd_t                   cmd;
    smdu_stat_t                  stat;
    logic signed [DATA_WIDTH-1:0] lhs, rhs, result;

    assign lhs = s_tdata[DATA_WIDTH-1:0];
    assign rhs = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

    smdu_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    smdu_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .cmd    (cmd),
        .lhs    (lhs),
        .rhs    (rhs),
        .func   (s_tuser),
        .stat   (stat),
        .result (result)
    );

    assign m_tdata = OUT_W'(unsigned'(result));

endmodule

### design/smdu_checker.sv
`timescale 1ns / 1ps
`include "signed_multiply_divide_unit_macros.svh"

module smdu_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [((DATA_WIDTH+7)/8)*8-1:0]    m_tdata
);

    // a result waiting to be taken stays put
    `SMDU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one transaction in the works at a time
    `SMDU_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // a new result shows up as the unit returns to idle
    `SMDU_ASSERT_NOW(a_result_at_idle, $rose(m_tvalid), s_tready)

endmodule

bind signed_multiply_divide_unit smdu_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_smdu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
